@@ rtl/sfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sfs_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_FLASH     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ONSET     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_REP_GAP   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TRIAL_GAP = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FLASHES   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_REPS      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TRIALS    = 3'd6;

  localparam logic [31:0] UnlimitedTrials = 32'hFFFF_FFFE;
  localparam logic [16:0] TrialNumMax     = 17'h1_FFFF;

  typedef enum logic [3:0] {
    EV_EXP_START   = 4'd0,
    EV_REST_STOP   = 4'd1,
    EV_TRIAL_START = 4'd2,
    EV_FLASH       = 4'd3,
    EV_FLASH_STOP  = 4'd4,
    EV_VISUAL_STOP = 4'd5,
    EV_TRIAL_STOP  = 4'd6,
    EV_REST_START  = 4'd7,
    EV_TARGET_CUE  = 4'd8,
    EV_FEEDBACK    = 4'd9,
    EV_VALUE       = 4'd10,
    EV_EXP_STOP    = 4'd11
  } event_e;

  typedef enum logic [2:0] {
    PH_NONE, PH_NOFLASH, PH_FLASH, PH_INTER, PH_REPREST, PH_TRIALREST,
    PH_TARGET, PH_FEEDBACK
  } phase_e;

  typedef struct packed {
    logic [15:0] prediction;
    logic        target_ready;
    logic [15:0] target_value;
    logic        quit;
  } tick_t;

  typedef struct packed {
    logic [3:0]  event_code;
    logic [15:0] event_value;
    logic        target_pop;
    logic        evidence_flush;
    logic        last;
  } event_t;

  // shared arithmetic unit request/response
  typedef struct packed {
    logic        start;
    logic        is_mod;
    logic [47:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

@@ rtl/sfs_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface sfs_tick_if;
  logic           valid;
  logic           ready;
  sfs_pkg::tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfs_event_if;
  logic            valid;
  logic            ready;
  sfs_pkg::event_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/sfs_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// bit-serial shift-add multiplier / restoring modulo, one bit a cycle
module sfs_alu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sfs_pkg::alu_req_t req_i,
  output sfs_pkg::alu_rsp_t      rsp_o
);

  logic        busy_q, busy_d;
  logic        mod_q, mod_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] acc_q, acc_d;
  logic [47:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic        done_q, done_d;
  logic [48:0] trial_rem;
  logic [48:0] rem_sh;

  always_comb begin
    busy_d = busy_q;
    mod_d  = mod_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    done_d = 1'b0;
    rem_sh    = {acc_q, a_q[47]};
    trial_rem = rem_sh - {17'd0, b_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      mod_d  = req_i.is_mod;
      cnt_d  = 6'd0;
      acc_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
    end else if (busy_q) begin
      if (mod_q) begin
        // restoring remainder, dividend bits from the top
        acc_d = trial_rem[48] ? rem_sh[47:0] : trial_rem[47:0];
        a_d   = {a_q[46:0], 1'b0};
      end else begin
        // multiply: a shifts left, b shifts right
        if (b_q[0]) acc_d = acc_q + a_q;
        a_d = {a_q[46:0], 1'b0};
        b_d = {1'b0, b_q[31:1]};
      end
      cnt_d = cnt_q + 6'd1;
      if ((mod_q && cnt_q == 6'd47) || (!mod_q && cnt_q == 6'd31)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mod_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mod_q  <= mod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

  property p_done_pulse;
    @(posedge clk_i) disable iff (!rst_ni) rsp_o.done |=> !rsp_o.done;
  endproperty
  assert property (p_done_pulse) else $error("alu done held");

  property p_done_after_busy;
    @(posedge clk_i) disable iff (!rst_ni) rsp_o.done |-> $past(busy_q);
  endproperty
  assert property (p_done_after_busy) else $error("alu done without work");

  property p_busy_start;
    @(posedge clk_i) disable iff (!rst_ni) $rose(busy_q) |-> $past(req_i.start);
  endproperty
  assert property (p_busy_start) else $error("alu busy without start");

endmodule
`default_nettype wire

@@ rtl/stimulus_flash_sequencer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// stimulus flash sequencer
// tick_if carries one beat per simulated tick (prediction, target head, quit);
// evt_if returns up to four event beats per tick, the final one with last set.
// configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle;
// tick_if.ready drops during a write, so a tick never shares the write edge.
// each running tick goes through a small sequencer around one bit-serial
// arithmetic unit: two 32-step products (flash span, trial length) and one
// 48-step modulo for the time within a repetition, each with a registered result.
// the tick beat is latched, then passes S_PRE, the two products, the modulo and
// S_DECIDE before the first event beat is offered; a tick with no event frees
// the input after S_DECIDE, one with events once its last beat is taken.
// ticks while waiting for quit or after the run is done skip the arithmetic and
// go from S_PRE back to idle, or through S_DRAIN when the final stop beat goes out.
// events are stored in a four-entry buffer and then drained one beat a cycle;
// when the receiver stalls the drain simply waits, and no new tick is taken
// until every event of the current tick has gone.
// reset restores the register defaults (flash 25, onset 50, trial gap 1000, repetition
// gap 0, twelve flashes, ten repetitions, unlimited trials) and the initial trial windows.
// once the run is done every later tick is taken and gives no event.
module stimulus_flash_sequencer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  sfs_tick_if.sink         tick_if,
  sfs_event_if.source      evt_if
);

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_MUL_SPAN, S_MUL_TDUR, S_MOD, S_DECIDE, S_EMIT, S_DRAIN
  } state_e;

  state_e state_q;

  // configuration
  logic [15:0] flash_q, onset_q, rep_gap_q, trial_gap_q, trials_q;
  logic [7:0]  flashes_q, reps_q;

  // sequencing state
  logic [31:0] now_q, trial_start_q, fb_start_q, fb_end_q, cue_start_q, cue_end_q;
  logic [31:0] nf_at_q, nfs_at_q;
  logic [16:0] trial_num_q;
  sfs_pkg::phase_e last_ph_q, prior_ph_q;
  logic [15:0] held_q;
  logic [1:0]  fin_q;
  localparam logic [1:0] FinRun = 2'd0, FinWait = 2'd1, FinDone = 2'd2;

  // tick latch and arithmetic results
  sfs_pkg::tick_t tk_q;
  logic [47:0] span_q, tdur_q, tir_q;

  // event buffer
  sfs_pkg::event_t ev_q [4];
  logic [2:0] ev_n_q;
  logic [1:0] ev_rd_q;

  sfs_pkg::alu_req_t alu_req;
  sfs_pkg::alu_rsp_t alu_rsp;

  sfs_alu u_alu (.clk_i, .rst_ni, .req_i(alu_req), .rsp_o(alu_rsp));

  // derived figures
  logic [31:0] eff;
  logic [31:0] p8;
  logic [31:0] tit;
  logic [47:0] rep_len, period, period_from_span;
  logic [7:0]  nf;
  logic        trial_over;
  assign eff     = (trials_q != 16'd0) ? {16'd0, trials_q} : sfs_pkg::UnlimitedTrials;
  assign p8      = {19'd0, trial_gap_q[15:3]};
  assign tit     = now_q - trial_start_q;
  assign nf      = (flashes_q != 8'd0) ? flashes_q : 8'd1;
  assign rep_len = span_q + {32'd0, flash_q};
  assign period  = rep_len + {32'd0, rep_gap_q};
  // span straight from the unit, before span_q has taken it
  assign period_from_span = alu_rsp.result + {32'd0, flash_q} + {32'd0, rep_gap_q};
  assign trial_over = ({15'd0, trial_num_q} > eff);

  assign tick_if.ready = (state_q == S_IDLE) && !cfg_we_i;
  assign evt_if.valid  = (state_q == S_DRAIN);
  assign evt_if.data   = ev_q[ev_rd_q];

  // the arithmetic unit is started on entry to each product and the modulo
  always_comb begin
    alu_req = '0;
    unique case (state_q)
      S_PRE: begin
        alu_req.start = (fin_q == FinRun) && !trial_over;
        alu_req.a     = {40'd0, nf - 8'd1};
        alu_req.b     = {16'd0, onset_q};
      end
      S_MUL_SPAN: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.a     = {40'd0, reps_q};
          alu_req.b     = period_from_span[31:0];
        end
      end
      S_MUL_TDUR: begin
        if (alu_rsp.done) begin
          alu_req.start  = 1'b1;
          alu_req.is_mod = 1'b1;
          alu_req.a      = {16'd0, tit};
          alu_req.b      = period[31:0];
        end
      end
      default: ;
    endcase
  end

  // one decision pass, as combinational next-state of the tick
  logic [31:0] d_trial_start, d_fb_start, d_fb_end, d_cue_start, d_cue_end;
  logic [31:0] d_nf_at, d_nfs_at;
  logic [16:0] d_tn;
  sfs_pkg::phase_e st, d_last;
  logic [15:0] d_held;
  logic [1:0]  d_fin;
  sfs_pkg::event_t ev [4];
  logic [2:0] n;
  logic flush;

  function automatic sfs_pkg::event_t mk(logic [3:0] c, logic [15:0] v, logic pop,
                                         logic fl);
    sfs_pkg::event_t e;
    e.event_code     = c;
    e.event_value    = v;
    e.target_pop     = pop;
    e.evidence_flush = fl;
    e.last           = 1'b0;
    return e;
  endfunction

  always_comb begin
    logic [31:0] base;
    logic        newtr;
    logic [31:0] tit2;
    logic [47:0] tir_use;
    d_trial_start = trial_start_q; d_fb_start = fb_start_q; d_fb_end = fb_end_q;
    d_cue_start = cue_start_q; d_cue_end = cue_end_q;
    d_nf_at = nf_at_q; d_nfs_at = nfs_at_q; d_tn = trial_num_q;
    d_last = last_ph_q; d_held = held_q; d_fin = fin_q;
    st = prior_ph_q; flush = 1'b0; n = 3'd0;
    for (int i = 0; i < 4; i++) ev[i] = '0;
    base = now_q; newtr = 1'b0;

    if (tk_q.prediction != 16'd0 && st != sfs_pkg::PH_TRIALREST &&
        st != sfs_pkg::PH_FEEDBACK && st != sfs_pkg::PH_TARGET) newtr = 1'b1;
    if (newtr) begin
      d_trial_start = now_q + {16'd0, trial_gap_q};
      d_fb_start = now_q + {p8[30:0], 1'b0};
      d_fb_end = d_fb_start + {p8[30:0], 1'b0};
      d_cue_start = d_fb_end + p8;
      d_cue_end = d_cue_start + {p8[30:0], 1'b0};
      d_nf_at = 32'd0; d_nfs_at = {16'd0, flash_q};
      if (d_tn < sfs_pkg::TrialNumMax) d_tn = d_tn + 17'd1;
    end
    // a trial cut short restarts its clock at this tick
    tit2 = now_q - d_trial_start;
    tir_use = newtr ? 48'd0 : tir_q;

    if (now_q < d_trial_start) begin
      st = sfs_pkg::PH_TRIALREST;
      if (now_q >= d_fb_start && now_q <= d_fb_end) begin
        st = sfs_pkg::PH_FEEDBACK;
        if (last_ph_q == sfs_pkg::PH_FEEDBACK && tk_q.prediction != 16'd0) begin
          d_held = tk_q.prediction;
          st = sfs_pkg::PH_TRIALREST;
          flush = 1'b1;
        end
      end
      if (now_q >= d_cue_start && now_q <= d_cue_end) st = sfs_pkg::PH_TARGET;
    end else if ({15'd0, d_tn} != eff) begin
      if ({16'd0, tit2} >= tdur_q) begin
        d_trial_start = base + {16'd0, trial_gap_q};
        d_fb_start = base + {p8[30:0], 1'b0};
        d_fb_end = d_fb_start + {p8[30:0], 1'b0};
        d_cue_start = d_fb_end + p8;
        d_cue_end = d_cue_start + {p8[30:0], 1'b0};
        d_nf_at = 32'd0; d_nfs_at = {16'd0, flash_q};
        if (d_tn < sfs_pkg::TrialNumMax) d_tn = d_tn + 17'd1;
        st = sfs_pkg::PH_TRIALREST;
      end else if (tir_use >= rep_len) begin
        st = sfs_pkg::PH_REPREST;
        d_nf_at = 32'd0; d_nfs_at = {16'd0, flash_q};
      end else begin
        if (tir_use < {16'd0, d_nf_at}) st = sfs_pkg::PH_INTER;
        if (tir_use >= {16'd0, d_nf_at} && last_ph_q != sfs_pkg::PH_FLASH &&
            {16'd0, d_nf_at} <= span_q) begin
          st = sfs_pkg::PH_FLASH;
          d_nf_at = d_nf_at + {16'd0, onset_q};
        end
        if (tir_use >= {16'd0, d_nfs_at} && last_ph_q != sfs_pkg::PH_NOFLASH) begin
          st = sfs_pkg::PH_NOFLASH;
          d_nfs_at = d_nfs_at + {16'd0, onset_q};
        end
      end
    end else begin
      if (d_tn < sfs_pkg::TrialNumMax) d_tn = d_tn + 17'd1;
      st = sfs_pkg::PH_NONE;
    end

    if (st != last_ph_q) begin
      priority if (last_ph_q == sfs_pkg::PH_TRIALREST) begin
        if (st != sfs_pkg::PH_TARGET && st != sfs_pkg::PH_FEEDBACK) begin
          ev[n[1:0]] = mk(sfs_pkg::EV_REST_STOP, 16'd0, 1'b0, flush); n = n + 3'd1;
          flush = 1'b0;
          if (st != sfs_pkg::PH_NONE) begin
            ev[n[1:0]] = mk(sfs_pkg::EV_TRIAL_START, 16'd0, 1'b0, 1'b0); n = n + 3'd1;
          end
        end
      end else if (last_ph_q == sfs_pkg::PH_TARGET) begin
        d_held = 16'd0;
      end else if (last_ph_q == sfs_pkg::PH_NONE) begin
        ev[n[1:0]] = mk(sfs_pkg::EV_EXP_START, 16'd0, 1'b0, flush); n = n + 3'd1;
        flush = 1'b0;
      end else begin
      end
      unique case (st)
        sfs_pkg::PH_FLASH: begin
          ev[n[1:0]] = mk(sfs_pkg::EV_FLASH, 16'd0, 1'b0, flush); n = n + 3'd1;
        end
        sfs_pkg::PH_NOFLASH: begin
          ev[n[1:0]] = mk(sfs_pkg::EV_FLASH_STOP, 16'd0, 1'b0, flush); n = n + 3'd1;
        end
        sfs_pkg::PH_REPREST: begin
          ev[n[1:0]] = mk(sfs_pkg::EV_VISUAL_STOP, 16'd0, 1'b0, flush); n = n + 3'd1;
        end
        sfs_pkg::PH_TRIALREST: begin
          if (last_ph_q == sfs_pkg::PH_TARGET || last_ph_q == sfs_pkg::PH_FEEDBACK) begin
            ev[n[1:0]] = mk(sfs_pkg::EV_VISUAL_STOP, 16'd0, 1'b0, flush); n = n + 3'd1;
            flush = 1'b0;
          end
          if (last_ph_q != sfs_pkg::PH_NONE && last_ph_q != sfs_pkg::PH_TARGET &&
              last_ph_q != sfs_pkg::PH_FEEDBACK) begin
            ev[n[1:0]] = mk(sfs_pkg::EV_TRIAL_STOP, 16'd0, 1'b0, flush); n = n + 3'd1;
            ev[n[1:0]] = mk(sfs_pkg::EV_REST_START, 16'd0, 1'b0, 1'b0); n = n + 3'd1;
          end
        end
        sfs_pkg::PH_TARGET: begin
          if (tk_q.target_ready) begin
            ev[n[1:0]] = mk(sfs_pkg::EV_TARGET_CUE, 16'd0, 1'b0, flush); n = n + 3'd1;
            ev[n[1:0]] = mk(sfs_pkg::EV_VALUE, tk_q.target_value, 1'b1, 1'b0);
            n = n + 3'd1;
          end
        end
        sfs_pkg::PH_FEEDBACK: begin
          if (d_held == 16'd0) begin
            ev[n[1:0]] = mk(sfs_pkg::EV_FEEDBACK, 16'd0, 1'b0, flush);
          end else begin
            ev[n[1:0]] = mk(sfs_pkg::EV_VALUE, d_held, 1'b0, flush);
            d_held = 16'd0;
          end
          n = n + 3'd1;
        end
        default: begin
          ev[n[1:0]] = mk(sfs_pkg::EV_TRIAL_STOP, 16'd0, 1'b0, flush); n = n + 3'd1;
        end
      endcase
      d_last = st;
    end
    if (tk_q.quit) begin
      if (n < 3'd4) begin
        ev[n[1:0]] = mk(sfs_pkg::EV_EXP_STOP, 16'd0, 1'b0, 1'b0); n = n + 3'd1;
      end
      d_fin = FinDone;
    end
    // mark the final beat of the tick
    if (n != 3'd0) ev[n[1:0] - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flash_q <= 16'd25; onset_q <= 16'd50; rep_gap_q <= 16'd0;
      trial_gap_q <= 16'd1000; flashes_q <= 8'd12; reps_q <= 8'd10; trials_q <= 16'd0;
      now_q <= '0;
      trial_start_q <= 32'd1000; fb_start_q <= 32'd250; fb_end_q <= 32'd500;
      cue_start_q <= 32'd625; cue_end_q <= 32'd875;
      nf_at_q <= '0; nfs_at_q <= 32'd25;
      trial_num_q <= '0;
      last_ph_q <= sfs_pkg::PH_NONE; prior_ph_q <= sfs_pkg::PH_NOFLASH;
      held_q <= '0; fin_q <= FinRun;
      ev_n_q <= '0; ev_rd_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            logic [15:0] fl, gp;
            fl = flash_q; gp = trial_gap_q;
            unique case (cfg_idx_i)
              sfs_pkg::REG_FLASH:     begin flash_q <= cfg_data_i; fl = cfg_data_i; end
              sfs_pkg::REG_ONSET:     onset_q <= cfg_data_i;
              sfs_pkg::REG_REP_GAP:   rep_gap_q <= cfg_data_i;
              sfs_pkg::REG_TRIAL_GAP: begin trial_gap_q <= cfg_data_i; gp = cfg_data_i; end
              sfs_pkg::REG_FLASHES:   flashes_q <= cfg_data_i[7:0];
              sfs_pkg::REG_REPS:      reps_q <= cfg_data_i[7:0];
              sfs_pkg::REG_TRIALS:    trials_q <= cfg_data_i;
              default: ;
            endcase
            if (cfg_idx_i <= sfs_pkg::REG_TRIALS && now_q == 32'd0 &&
                last_ph_q == sfs_pkg::PH_NONE && fin_q == FinRun) begin
              trial_start_q <= {16'd0, gp};
              fb_start_q <= {18'd0, gp[15:3], 1'b0};
              fb_end_q <= {17'd0, gp[15:3], 2'b0};
              cue_start_q <= {17'd0, gp[15:3], 2'b0} + {19'd0, gp[15:3]};
              cue_end_q <= {17'd0, gp[15:3], 2'b0} + {19'd0, gp[15:3]} +
                           {18'd0, gp[15:3], 1'b0};
              nf_at_q <= '0; nfs_at_q <= {16'd0, fl};
            end
          end else if (tick_if.valid) begin
            tk_q <= tick_if.data;
            state_q <= S_PRE;
          end
        end
        S_PRE: begin
          // handle finished / waiting before any arithmetic
          if (fin_q == FinDone) begin
            state_q <= S_IDLE;
          end else if (fin_q == FinWait || trial_over) begin
            fin_q <= FinWait;
            if (tk_q.quit) begin
              ev_q[0] <= '{event_code: sfs_pkg::EV_EXP_STOP, event_value: 16'd0,
                           target_pop: 1'b0, evidence_flush: 1'b0, last: 1'b1};
              ev_n_q <= 3'd1; ev_rd_q <= '0;
              fin_q <= FinDone;
              state_q <= S_DRAIN;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            state_q <= S_MUL_SPAN;
          end
        end
        S_MUL_SPAN: begin
          if (alu_rsp.done) begin
            span_q <= alu_rsp.result;
            state_q <= S_MUL_TDUR;
          end
        end
        S_MUL_TDUR: begin
          if (alu_rsp.done) begin
            tdur_q <= alu_rsp.result;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (alu_rsp.done) begin
            tir_q <= (period == 48'd0) ? 48'd0 : alu_rsp.result;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          trial_start_q <= d_trial_start; fb_start_q <= d_fb_start;
          fb_end_q <= d_fb_end; cue_start_q <= d_cue_start; cue_end_q <= d_cue_end;
          nf_at_q <= d_nf_at; nfs_at_q <= d_nfs_at; trial_num_q <= d_tn;
          last_ph_q <= d_last; prior_ph_q <= st; held_q <= d_held; fin_q <= d_fin;
          now_q <= now_q + 32'd1;
          for (int i = 0; i < 4; i++) ev_q[i] <= ev[i];
          ev_n_q <= n; ev_rd_q <= '0;
          state_q <= (n != 3'd0) ? S_DRAIN : S_IDLE;
        end
        S_DRAIN: begin
          if (evt_if.ready) begin
            if ({1'b0, ev_rd_q} + 3'd1 == ev_n_q) state_q <= S_IDLE;
            else ev_rd_q <= ev_rd_q + 2'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  property p_ready_idle;
    @(posedge clk_i) disable iff (!rst_ni) tick_if.ready |-> !evt_if.valid;
  endproperty
  assert property (p_ready_idle) else $error("ready while draining");

  property p_count;
    @(posedge clk_i) disable iff (!rst_ni) evt_if.valid |-> ev_n_q != 3'd0;
  endproperty
  assert property (p_count) else $error("drain with no events");

  property p_done_quiet;
    @(posedge clk_i) disable iff (!rst_ni)
      (fin_q == FinDone && state_q == S_PRE) |=> state_q == S_IDLE;
  endproperty
  assert property (p_done_quiet) else $error("done run did work");

endmodule
`default_nettype wire
